// ===== design/nlc_pkg.sv =====
package nlc_pkg;
  localparam int MASSES = 64;
  localparam int FRAC_BITS = 24;
  localparam int DT_FRAC = 24;
  localparam int MAX_OUT = 64;
  localparam int AW = $clog2(MASSES);
  localparam int OUT_N = (MASSES < MAX_OUT) ? MASSES : MAX_OUT;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_STEP = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  localparam logic REG_STEP_SIZE = 1'b0;
  localparam logic REG_CUBIC = 1'b1;

  localparam logic [23:0] STEP_SIZE_RESET = 24'd83886;
  localparam logic [31:0] CUBIC_RESET = 32'h0100_0000;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = 32'sh7fff_ffff;
    else if (v < -66'sd2147483648) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction
endpackage

// ===== design/nonlinear_chain_leapfrog_step.sv =====
// channel  direction  signals
// in       input      in_valid/in_ready: func, mass_index, position, velocity
// out      output     out_valid/out_ready: mass_index_res, position_res, velocity_res, last
// cfg      input      cfg_we, cfg_index, cfg_data
// a write is done in the idle state; a readout steps through S_OUTA, S_OUTRD and S_OUTW
// for each mass, plus output stalls. a step runs two passes over the interior masses,
// each mass going through S_RD0 to S_WB2 for the memory reads of the three neighbors and
// the multiply chain, with a copy of the new positions, one per cycle, between the passes.
// reset clears the chain mass by mass in S_CLEAR before the first word is taken.
// out_ready low holds the readout sweep; in_ready is low while a command runs.
module nonlinear_chain_leapfrog_step (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         func,
  input  logic [5:0]         mass_index,
  input  logic signed [31:0] position,
  input  logic signed [31:0] velocity,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         mass_index_res,
  output logic signed [31:0] position_res,
  output logic signed [31:0] velocity_res,
  output logic               last,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);
  localparam int AW = nlc_pkg::AW;
  localparam int FB = nlc_pkg::FRAC_BITS;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD0, S_RD1, S_RD2, S_F0, S_F1, S_F2, S_F3, S_F4, S_F5, S_WB,
    S_WB2, S_OUTA, S_OUTRD, S_OUTW
  } state_t;

  state_t state;
  logic [23:0] step_size;
  logic signed [31:0] cubic;

  logic signed [31:0] pos_mem [nlc_pkg::MASSES];
  logic signed [31:0] vel_mem [nlc_pkg::MASSES];
  logic signed [31:0] hv_mem [nlc_pkg::MASSES];
  logic signed [31:0] np_mem [nlc_pkg::MASSES];

  logic [AW-1:0] idx;
  logic [AW-1:0] raddr;
  logic [1:0] phase;
  logic signed [31:0] pos_q, vel_q, hv_q, np_q;
  logic signed [31:0] xl, xc, xr, vb;
  logic signed [31:0] lin, dr, dl, sqr, sql, cbr, cbl, nl, f, hv;

  always_ff @(posedge clk) begin
    pos_q <= pos_mem[raddr];
    vel_q <= vel_mem[raddr];
    hv_q <= hv_mem[raddr];
    np_q <= np_mem[raddr];
  end

  function automatic logic signed [31:0] fsh(input logic signed [65:0] p, input int s);
    return nlc_pkg::sat32(p >>> s);
  endfunction

  logic signed [65:0] m_r, m_l;
  logic signed [65:0] m_dt;
  always_comb begin
    m_r = 66'(sqr) * 66'(dr);
    m_l = 66'(sql) * 66'(dl);
    m_dt = 66'(f) * $signed({42'd0, step_size});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      idx <= '0;
      raddr <= '0;
      phase <= '0;
      step_size <= nlc_pkg::STEP_SIZE_RESET;
      cubic <= nlc_pkg::CUBIC_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == nlc_pkg::REG_STEP_SIZE) step_size <= cfg_data[23:0];
        else cubic <= cfg_data;
      end
      case (state)
        S_CLEAR: begin
          pos_mem[idx] <= '0;
          vel_mem[idx] <= '0;
          idx <= idx + 1'b1;
          if (idx == AW'(nlc_pkg::MASSES - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            case (func)
              nlc_pkg::FUNC_WRITE: begin
                if (mass_index >= 6'd1 && 32'(mass_index) < nlc_pkg::MASSES - 1) begin
                  pos_mem[AW'(mass_index)] <= position;
                  vel_mem[AW'(mass_index)] <= velocity;
                end
              end
              nlc_pkg::FUNC_STEP: begin
                phase <= 2'd0;
                idx <= AW'(1);
                raddr <= '0;
                state <= S_RD0;
              end
              nlc_pkg::FUNC_READ: begin
                idx <= '0;
                raddr <= '0;
                state <= S_OUTA;
              end
              default: ;
            endcase
          end
        end
        S_RD0: begin
          raddr <= idx;
          state <= S_RD1;
        end
        S_RD1: begin
          xl <= (phase == 2'd0) ? pos_q : pos_q;
          raddr <= idx + 1'b1;
          state <= S_RD2;
        end
        S_RD2: begin
          xc <= pos_q;
          vb <= (phase == 2'd0) ? vel_q : hv_q;
          state <= S_F0;
        end
        S_F0: begin
          xr <= pos_q;
          state <= S_F1;
        end
        S_F1: begin
          lin <= nlc_pkg::sat32(66'(xr) - 66'(xc) - 66'(xc) + 66'(xl));
          dr <= nlc_pkg::sat32(66'(xr) - 66'(xc));
          dl <= nlc_pkg::sat32(66'(xc) - 66'(xl));
          state <= S_F2;
        end
        S_F2: begin
          sqr <= fsh(66'(dr) * 66'(dr), FB);
          sql <= fsh(66'(dl) * 66'(dl), FB);
          state <= S_F3;
        end
        S_F3: begin
          cbr <= fsh(m_r, FB);
          cbl <= fsh(m_l, FB);
          state <= S_F4;
        end
        S_F4: begin
          nl <= fsh(66'(cubic) * 66'(nlc_pkg::sat32(66'(cbr) - 66'(cbl))), FB);
          state <= S_F5;
        end
        S_F5: begin
          f <= nlc_pkg::sat32(66'(lin) + 66'(nl));
          state <= S_WB;
          phase[1] <= 1'b0;
        end
        S_WB: begin
          hv <= nlc_pkg::sat32(66'(vb) + (m_dt >>> (nlc_pkg::DT_FRAC + 1)));
          state <= S_WB2;
        end
        S_WB2: begin
          if (phase == 2'd0) begin
            hv_mem[idx] <= hv;
            np_mem[idx] <= nlc_pkg::sat32(66'(xc) + ((66'(hv) *
              $signed({42'd0, step_size})) >>> nlc_pkg::DT_FRAC));
          end else begin
            vel_mem[idx] <= hv;
          end
          if (idx == AW'(nlc_pkg::MASSES - 2)) begin
            if (phase == 2'd0) begin
              phase <= 2'd2;
              idx <= AW'(1);
              raddr <= AW'(1);
              state <= S_OUTW;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            idx <= idx + 1'b1;
            raddr <= idx;
            state <= S_RD0;
          end
        end
        S_OUTA: begin
          state <= S_OUTRD;
        end
        S_OUTRD: begin
          if (phase == 2'd2) begin
            state <= S_OUTW;
          end else begin
            out_valid <= 1'b1;
            mass_index_res <= 6'(idx);
            position_res <= pos_q;
            velocity_res <= vel_q;
            last <= (32'(idx) == nlc_pkg::OUT_N - 1);
            state <= S_OUTW;
          end
        end
        S_OUTW: begin
          if (phase == 2'd2) begin
            // copy next positions, one per cycle; np_q follows raddr
            if (raddr != idx) pos_mem[idx] <= np_q;
            if (raddr == idx) raddr <= idx + 1'b1;
            else if (idx == AW'(nlc_pkg::MASSES - 2)) begin
              phase <= 2'd1;
              idx <= AW'(1);
              raddr <= '0;
              state <= S_RD0;
            end else begin
              idx <= idx + 1'b1;
              raddr <= idx + 2'd2;
            end
          end else if (out_ready) begin
            out_valid <= 1'b0;
            if (32'(idx) == nlc_pkg::OUT_N - 1) state <= S_IDLE;
            else begin
              idx <= idx + 1'b1;
              raddr <= idx + 1'b1;
              state <= S_OUTA;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);
endmodule

// ===== tb/sv/nlc_checker.sv =====
`timescale 1ns / 100ps

module nlc_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         func,
  input  logic [5:0]         mass_index,
  input  logic signed [31:0] position,
  input  logic signed [31:0] velocity,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [5:0]         mass_index_res,
  input  logic signed [31:0] position_res,
  input  logic signed [31:0] velocity_res,
  input  logic               last,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 errors,
  output int                 pending
);

  typedef struct packed {
    logic [5:0]  idx;
    logic [31:0] pos;
    logic [31:0] vel;
    logic        lst;
  } mass_word_t;

  mass_word_t readout_q[$];
  longint chain_pos[nlc_pkg::MASSES];
  longint chain_vel[nlc_pkg::MASSES];
  longint half_vel[nlc_pkg::MASSES];
  longint next_pos[nlc_pkg::MASSES];
  logic [23:0] dt;
  logic signed [31:0] coef;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint cube_q(longint d);
    longint sq;
    sq = clamp32((d * d) >>> nlc_pkg::FRAC_BITS);
    return clamp32((sq * d) >>> nlc_pkg::FRAC_BITS);
  endfunction

  function automatic longint spring_force(input longint x[nlc_pkg::MASSES], int i);
    longint lin, dr, dl, cd, nl;
    lin = clamp32(x[i+1] - 2 * x[i] + x[i-1]);
    dr = clamp32(x[i+1] - x[i]);
    dl = clamp32(x[i] - x[i-1]);
    cd = clamp32(cube_q(dr) - cube_q(dl));
    nl = clamp32((longint'(coef) * cd) >>> nlc_pkg::FRAC_BITS);
    return clamp32(lin + nl);
  endfunction

  task automatic leapfrog();
    longint f, h;
    h = longint'({40'b0, dt});
    for (int i = 1; i < nlc_pkg::MASSES - 1; i++) begin
      f = spring_force(chain_pos, i);
      half_vel[i] = clamp32(chain_vel[i] + ((f * h) >>> (nlc_pkg::DT_FRAC + 1)));
      next_pos[i] = clamp32(chain_pos[i] + ((half_vel[i] * h) >>> nlc_pkg::DT_FRAC));
    end
    for (int i = 1; i < nlc_pkg::MASSES - 1; i++) chain_pos[i] = next_pos[i];
    for (int i = 1; i < nlc_pkg::MASSES - 1; i++) begin
      f = spring_force(chain_pos, i);
      chain_vel[i] = clamp32(half_vel[i] + ((f * h) >>> (nlc_pkg::DT_FRAC + 1)));
    end
  endtask

  assign pending = readout_q.size();

  always @(posedge clk) begin
    mass_word_t w;
    if (rst) begin
      for (int i = 0; i < nlc_pkg::MASSES; i++) begin
        chain_pos[i] = 0;
        chain_vel[i] = 0;
      end
      dt = nlc_pkg::STEP_SIZE_RESET;
      coef = nlc_pkg::CUBIC_RESET;
      readout_q.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == nlc_pkg::REG_STEP_SIZE) dt = cfg_data[23:0];
        else coef = cfg_data;
      end
      if (in_valid && in_ready) begin
        case (func)
          nlc_pkg::FUNC_WRITE: begin
            if (mass_index >= 1 && mass_index < nlc_pkg::MASSES - 1) begin
              chain_pos[mass_index] = longint'(position);
              chain_vel[mass_index] = longint'(velocity);
            end
          end
          nlc_pkg::FUNC_STEP: leapfrog();
          nlc_pkg::FUNC_READ: begin
            for (int k = 0; k < nlc_pkg::OUT_N; k++) begin
              w.idx = k[5:0];
              w.pos = chain_pos[k][31:0];
              w.vel = chain_vel[k][31:0];
              w.lst = (k == nlc_pkg::OUT_N - 1);
              readout_q.push_back(w);
            end
          end
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (readout_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected word: idx %0d pos %h vel %h last %b",
                     mass_index_res, position_res, velocity_res, last);
        end else begin
          w = readout_q.pop_front();
          if (w.idx !== mass_index_res || w.pos !== position_res ||
              w.vel !== velocity_res || w.lst !== last) begin
            errors++;
            if (errors <= 10)
              $display({"mismatch: exp idx %0d pos %h vel %h last %b, ",
                        "got idx %0d pos %h vel %h last %b"},
                       w.idx, w.pos, w.vel, w.lst,
                       mass_index_res, position_res, velocity_res, last);
          end
        end
      end
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 1500;
  localparam int HOLD_CYCLES = 2000;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] func = nlc_pkg::FUNC_WRITE;
  logic [5:0] mass_index = 0;
  logic signed [31:0] position = 0;
  logic signed [31:0] velocity = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [5:0] mass_index_res;
  logic signed [31:0] position_res;
  logic signed [31:0] velocity_res;
  logic last;
  logic cfg_we = 0;
  logic cfg_index = nlc_pkg::REG_STEP_SIZE;
  logic [31:0] cfg_data = 0;
  int errors;
  int pending;
  logic noidle = 0;
  logic hold_go = 0;
  int quiet = 0;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  nonlinear_chain_leapfrog_step uut (.*);

  nlc_checker chk (.*);

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    out_ready = 0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_go) begin
        out_ready = 0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_go = 0;
      end else begin
        out_ready = noidle || ($urandom_range(99) >= 33);
      end
    end
  end

  task automatic send(logic [1:0] f, logic [5:0] idx, logic [31:0] p, logic [31:0] v);
    while (!noidle && $urandom_range(99) < 33) begin
      in_valid = 0;
      @(negedge clk);
    end
    func = f;
    mass_index = idx;
    position = p;
    velocity = v;
    in_valid = 1;
    while (!in_ready) @(negedge clk);
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic set_cfg(logic [23:0] h, logic [31:0] b);
    while (pending != 0 || !in_ready) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we = 1;
    cfg_index = nlc_pkg::REG_STEP_SIZE;
    cfg_data = {8'b0, h};
    @(negedge clk);
    cfg_index = nlc_pkg::REG_CUBIC;
    cfg_data = b;
    @(negedge clk);
    cfg_we = 0;
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(33554432) - 16777216;
      2: return $urandom_range(2097152) - 1048576;
      default: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
    endcase
  endfunction

  task automatic random_items(int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 55)
        send(nlc_pkg::FUNC_WRITE, 6'($urandom_range(1, nlc_pkg::MASSES - 2)),
             rand_val(), rand_val());
      else if (r < 62) send(nlc_pkg::FUNC_WRITE, 6'($urandom), $urandom, $urandom);
      else if (r < 78) send(nlc_pkg::FUNC_STEP, 6'($urandom), $urandom, $urandom);
      else if (r < 94) send(nlc_pkg::FUNC_READ, 6'($urandom), $urandom, $urandom);
      else send(FUNC_UNUSED, 6'($urandom), $urandom, $urandom);
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst = 0;
    set_cfg(nlc_pkg::STEP_SIZE_RESET, nlc_pkg::CUBIC_RESET);

    // extremes, ignored writes, unused code
    send(nlc_pkg::FUNC_WRITE, 1, 32'h7fff_ffff, 32'h8000_0000);
    send(nlc_pkg::FUNC_WRITE, 6'(nlc_pkg::MASSES - 2), 32'h8000_0000, 32'h7fff_ffff);
    send(nlc_pkg::FUNC_WRITE, 0, 32'h1234_5678, 32'h1234_5678);
    send(nlc_pkg::FUNC_WRITE, 6'(nlc_pkg::MASSES - 1), 32'hffff_ffff, 32'hffff_ffff);
    send(FUNC_UNUSED, 6'h3f, 32'hffff_ffff, 32'hffff_ffff);
    send(nlc_pkg::FUNC_READ, 0, 0, 0);
    send(nlc_pkg::FUNC_STEP, 0, 0, 0);
    send(nlc_pkg::FUNC_READ, 6'h3f, 0, 0);
    for (int i = 2; i < 12; i++)
      send(nlc_pkg::FUNC_WRITE, 6'(i), (i - 6) * 32'sd2000000, 0);
    send(nlc_pkg::FUNC_STEP, 0, 0, 0);
    send(nlc_pkg::FUNC_STEP, 0, 0, 0);
    send(nlc_pkg::FUNC_READ, 0, 0, 0);

    // receiver stalls while reads pile up
    while (pending != 0) @(negedge clk);
    hold_go = 1;
    send(nlc_pkg::FUNC_READ, 0, 0, 0);
    send(nlc_pkg::FUNC_READ, 0, 0, 0);
    send(nlc_pkg::FUNC_READ, 0, 0, 0);

    random_items(25);
    set_cfg(24'd0, 32'h0000_0000);
    random_items(20);
    set_cfg(24'hff_ffff, 32'h8000_0000);
    noidle = 1;
    random_items(20);
    noidle = 0;
    set_cfg(24'hff_ffff, 32'h7fff_ffff);
    random_items(15);
    set_cfg(24'($urandom), $urandom);
    random_items(20);

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
